[sv/navdata_packet_tlv_parser_top_defines.svh]
// Assertion macros shared by the parser modules.
`ifndef NAVDATA_PACKET_TLV_PARSER_TOP_DEFINES_SVH
`define NAVDATA_PACKET_TLV_PARSER_TOP_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define NTLV_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define NTLV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define NTLV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ntlv_pkg.sv]
package ntlv_pkg;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       end_of_packet;
   } ntlv_req_type;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [1:0]  tag_index;
      logic [31:0] field_value;
      logic [1:0]  packet_status;
      logic        last_of_packet;
   } ntlv_rsp_type;

   // Up to two results leave the decoder for one byte; with two, the end word is second.
   typedef struct packed {
      logic [1:0]   num;
      ntlv_rsp_type first;
      ntlv_rsp_type second;
   } ntlv_push_type;

   typedef struct packed {
      logic [15:0] demo_tag;
      logic [15:0] vis_tag;
   } ntlv_cfg_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_STATUS,
      PH_SEQ,
      PH_SKIP,
      PH_TAG,
      PH_LEN,
      PH_BODY,
      PH_DRAIN
   } ntlv_phase_type;

   localparam logic [4:0] CODE_STATUS     = 5'd0;
   localparam logic [4:0] CODE_SEQUENCE   = 5'd1;
   localparam logic [4:0] CODE_CTRL_STATE = 5'd2;
   localparam logic [4:0] CODE_DEMO_BASE  = 5'd2;
   localparam logic [4:0] CODE_TAG_COUNT  = 5'd11;
   localparam logic [4:0] CODE_TAG_TYPE   = 5'd12;
   localparam logic [4:0] CODE_END        = 5'd18;

   localparam logic [1:0] ST_BUSY       = 2'd0;
   localparam logic [1:0] ST_OK         = 2'd1;
   localparam logic [1:0] ST_BAD_HEADER = 2'd2;
   localparam logic [1:0] ST_ZERO_LEN   = 2'd3;

   localparam logic REG_DEMO_TAG = 1'b0;
   localparam logic REG_VIS_TAG  = 1'b1;

   localparam logic [15:0] DEMO_TAG_RESET = 16'd0;
   localparam logic [15:0] VIS_TAG_RESET  = 16'd16;

   localparam logic [31:0] MAGIC_WORD       = 32'h5566_7788;
   localparam logic [15:0] OPT_HEADER_BYTES = 16'd4;
   localparam logic [15:0] DEMO_LAST_WORD   = 16'd8;
   localparam logic [15:0] WORD_COUNT_MAX   = 16'hFFFF;
   localparam logic [2:0]  VISION_COLUMNS   = 3'd6;
   localparam logic [30:0] MAX_TAGS         = 31'd4;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

endpackage

[sv/ntlv_csr.sv]
module ntlv_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output ntlv_pkg::ntlv_cfg_type cfg
);

   logic [15:0] demo_ff, demo_in;
   logic [15:0] vision_ff, vision_in;
   logic        wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      demo_in   = demo_ff;
      vision_in = vision_ff;
      if (wr_en) begin
         unique case (paddr[2])
            ntlv_pkg::REG_DEMO_TAG: demo_in   = pwdata[15:0];
            ntlv_pkg::REG_VIS_TAG:  vision_in = pwdata[15:0];
            default:                demo_in   = demo_ff;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[1:0] == 2'd0) begin
         unique case (paddr[2])
            ntlv_pkg::REG_DEMO_TAG: prdata = {16'd0, demo_ff};
            ntlv_pkg::REG_VIS_TAG:  prdata = {16'd0, vision_ff};
            default:                prdata = 32'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         demo_ff   <= ntlv_pkg::DEMO_TAG_RESET;
         vision_ff <= ntlv_pkg::VIS_TAG_RESET;
      end else begin
         demo_ff   <= demo_in;
         vision_ff <= vision_in;
      end
   end

   assign cfg.demo_tag = demo_ff;
   assign cfg.vis_tag  = vision_ff;

endmodule

[sv/ntlv_decode.sv]
`include "navdata_packet_tlv_parser_top_defines.svh"

module ntlv_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  ntlv_pkg::ntlv_req_type in_data,
   input  ntlv_pkg::ntlv_cfg_type cfg,
   output logic                   busy,
   output ntlv_pkg::ntlv_push_type push
);

   logic                     stage_vld_ff;
   ntlv_pkg::ntlv_req_type   stage_ff;

   ntlv_pkg::ntlv_phase_type phase_ff, phase_in;
   logic [23:0]              asm_ff, asm_in;
   logic [1:0]               biw_ff, biw_in;
   logic [15:0]              tag_ff, tag_in;
   logic [15:0]              left_ff, left_in;
   logic [15:0]              wio_ff, wio_in;
   logic [31:0]              vcount_ff, vcount_in;
   logic [2:0]               col_ff, col_in;
   logic [30:0]              row_ff, row_in;
   logic                     err_ff, err_in;

   logic [7:0]               b;
   logic [31:0]              word;
   logic [15:0]              half;
   logic                     complete;
   logic [30:0]              row_next;
   logic                     fld_vld;
   ntlv_pkg::ntlv_rsp_type   fld;
   logic                     end_vld;
   ntlv_pkg::ntlv_rsp_type   end_rsp;

   assign b        = stage_ff.packet_byte;
   assign word     = {b, asm_ff};
   assign half     = {b, asm_ff[7:0]};
   assign complete = (biw_ff == 2'd3);
   assign row_next = row_ff + 31'd1;
   assign busy     = stage_vld_ff;

   always_comb begin
      phase_in  = phase_ff;
      asm_in    = asm_ff;
      biw_in    = biw_ff;
      tag_in    = tag_ff;
      left_in   = left_ff;
      wio_in    = wio_ff;
      vcount_in = vcount_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      err_in    = err_ff;
      fld_vld   = 1'b0;
      fld       = '0;
      end_vld   = 1'b0;
      end_rsp   = '0;
      push      = '0;

      if (stage_vld_ff) begin
         unique case (phase_ff)
            ntlv_pkg::PH_HEADER, ntlv_pkg::PH_STATUS,
            ntlv_pkg::PH_SEQ, ntlv_pkg::PH_SKIP: begin
               if (!complete) begin
                  asm_in = asm_ff | (24'(b) << {biw_ff, 3'b000});
                  biw_in = biw_ff + 2'd1;
               end else begin
                  asm_in = '0;
                  biw_in = '0;
                  unique case (phase_ff)
                     ntlv_pkg::PH_HEADER: begin
                        if (word != ntlv_pkg::MAGIC_WORD) begin
                           err_in               = 1'b1;
                           phase_in             = ntlv_pkg::PH_DRAIN;
                           fld_vld              = 1'b1;
                           fld.field_code       = ntlv_pkg::CODE_END;
                           fld.packet_status    = ntlv_pkg::ST_BAD_HEADER;
                           fld.last_of_packet   = 1'b1;
                        end else begin
                           phase_in = ntlv_pkg::PH_STATUS;
                        end
                     end
                     ntlv_pkg::PH_STATUS: begin
                        fld_vld         = 1'b1;
                        fld.field_code  = ntlv_pkg::CODE_STATUS;
                        fld.field_value = word;
                        phase_in        = ntlv_pkg::PH_SEQ;
                     end
                     ntlv_pkg::PH_SEQ: begin
                        fld_vld         = 1'b1;
                        fld.field_code  = ntlv_pkg::CODE_SEQUENCE;
                        fld.field_value = word;
                        phase_in        = ntlv_pkg::PH_SKIP;
                     end
                     default: phase_in = ntlv_pkg::PH_TAG;
                  endcase
               end
            end
            ntlv_pkg::PH_TAG: begin
               if (biw_ff == 2'd0) begin
                  asm_in = {16'd0, b};
                  biw_in = 2'd1;
               end else begin
                  tag_in   = half;
                  asm_in   = '0;
                  biw_in   = '0;
                  phase_in = ntlv_pkg::PH_LEN;
               end
            end
            ntlv_pkg::PH_LEN: begin
               if (biw_ff == 2'd0) begin
                  asm_in = {16'd0, b};
                  biw_in = 2'd1;
               end else begin
                  asm_in = '0;
                  biw_in = '0;
                  if (half == 16'd0) begin
                     err_in             = 1'b1;
                     phase_in           = ntlv_pkg::PH_DRAIN;
                     fld_vld            = 1'b1;
                     fld.field_code     = ntlv_pkg::CODE_END;
                     fld.packet_status  = ntlv_pkg::ST_ZERO_LEN;
                     fld.last_of_packet = 1'b1;
                  end else if (half <= ntlv_pkg::OPT_HEADER_BYTES) begin
                     phase_in = ntlv_pkg::PH_TAG;
                  end else begin
                     left_in   = half - ntlv_pkg::OPT_HEADER_BYTES;
                     wio_in    = '0;
                     vcount_in = '0;
                     row_in    = '0;
                     col_in    = '0;
                     phase_in  = ntlv_pkg::PH_BODY;
                  end
               end
            end
            ntlv_pkg::PH_BODY: begin
               if (!complete) begin
                  asm_in = asm_ff | (24'(b) << {biw_ff, 3'b000});
                  biw_in = biw_ff + 2'd1;
               end else begin
                  asm_in = '0;
                  biw_in = '0;
                  // Demo decoding wins when both tags are programmed alike.
                  if (tag_ff == cfg.demo_tag) begin
                     if (wio_ff == 16'd0) begin
                        fld_vld         = 1'b1;
                        fld.field_code  = ntlv_pkg::CODE_CTRL_STATE;
                        fld.field_value = {16'd0, word[31:16]};
                     end else if (wio_ff <= ntlv_pkg::DEMO_LAST_WORD) begin
                        fld_vld         = 1'b1;
                        fld.field_code  = 5'(wio_ff[3:0]) + ntlv_pkg::CODE_DEMO_BASE;
                        fld.field_value = word;
                     end
                  end else if (tag_ff == cfg.vis_tag) begin
                     if (wio_ff == 16'd0) begin
                        vcount_in       = word;
                        row_in          = '0;
                        col_in          = '0;
                        fld_vld         = 1'b1;
                        fld.field_code  = ntlv_pkg::CODE_TAG_COUNT;
                        fld.field_value = word;
                     end else if ((vcount_ff != 32'd0) && !vcount_ff[31]
                                  && (col_ff < ntlv_pkg::VISION_COLUMNS)) begin
                        if (row_ff < ntlv_pkg::MAX_TAGS) begin
                           fld_vld         = 1'b1;
                           fld.field_code  = ntlv_pkg::CODE_TAG_TYPE + 5'(col_ff);
                           fld.tag_index   = row_ff[1:0];
                           fld.field_value = word;
                        end
                        // Words come column by column: every row of one field, then the next.
                        if ({1'b0, row_next} >= vcount_ff) begin
                           row_in = '0;
                           col_in = col_ff + 3'd1;
                        end else begin
                           row_in = row_next;
                        end
                     end
                  end
                  if (wio_ff != ntlv_pkg::WORD_COUNT_MAX) begin
                     wio_in = wio_ff + 16'd1;
                  end
               end
               if (left_ff <= 16'd1) begin
                  left_in  = '0;
                  asm_in   = '0;
                  biw_in   = '0;
                  phase_in = ntlv_pkg::PH_TAG;
               end else begin
                  left_in = left_ff - 16'd1;
               end
            end
            default: phase_in = phase_ff;
         endcase

         if (stage_ff.end_of_packet) begin
            if (!err_in) begin
               end_vld                = 1'b1;
               end_rsp.field_code     = ntlv_pkg::CODE_END;
               end_rsp.packet_status  = (phase_in == ntlv_pkg::PH_HEADER) ?
                                        ntlv_pkg::ST_BAD_HEADER : ntlv_pkg::ST_OK;
               end_rsp.last_of_packet = 1'b1;
            end
            phase_in  = ntlv_pkg::PH_HEADER;
            asm_in    = '0;
            biw_in    = '0;
            tag_in    = '0;
            left_in   = '0;
            wio_in    = '0;
            vcount_in = '0;
            col_in    = '0;
            row_in    = '0;
            err_in    = 1'b0;
         end

         if (fld_vld && end_vld) begin
            push.num    = 2'd2;
            push.first  = fld;
            push.second = end_rsp;
         end else if (fld_vld) begin
            push.num   = 2'd1;
            push.first = fld;
         end else if (end_vld) begin
            push.num   = 2'd1;
            push.first = end_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         stage_ff <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         phase_ff     <= ntlv_pkg::PH_HEADER;
         asm_ff       <= '0;
         biw_ff       <= '0;
         tag_ff       <= '0;
         left_ff      <= '0;
         wio_ff       <= '0;
         vcount_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         stage_vld_ff <= in_accept;
         phase_ff     <= phase_in;
         asm_ff       <= asm_in;
         biw_ff       <= biw_in;
         tag_ff       <= tag_in;
         left_ff      <= left_in;
         wio_ff       <= wio_in;
         vcount_ff    <= vcount_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         err_ff       <= err_in;
      end
   end

   `NTLV_ASSERT_IMP(a_error_drains, clock, reset, err_ff, phase_ff == ntlv_pkg::PH_DRAIN, "error flag outside drain phase")
   `NTLV_ASSERT_IMP(a_pair_ends_packet, clock, reset, push.num == 2'd2, push.second.last_of_packet && (push.second.field_code == ntlv_pkg::CODE_END), "second word of a pair is not the packet end")
   `NTLV_ASSERT_IMP(a_half_word_count, clock, reset, (phase_ff == ntlv_pkg::PH_TAG) || (phase_ff == ntlv_pkg::PH_LEN), biw_ff <= 2'd1, "byte count too high in tag or length field")

endmodule

[sv/ntlv_fifo.sv]
`include "navdata_packet_tlv_parser_top_defines.svh"

module ntlv_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  ntlv_pkg::ntlv_push_type push,
   input  logic                    pop,
   output logic                    out_valid,
   output ntlv_pkg::ntlv_rsp_type  out_data,
   output logic [ntlv_pkg::FIFO_CW-1:0] count
);

   ntlv_pkg::ntlv_rsp_type            mem_ff [ntlv_pkg::FIFO_DEPTH];
   logic [ntlv_pkg::FIFO_AW-1:0]      wr_ff, wr_in;
   logic [ntlv_pkg::FIFO_AW-1:0]      rd_ff, rd_in;
   logic [ntlv_pkg::FIFO_CW-1:0]      cnt_ff, cnt_in;
   logic [ntlv_pkg::FIFO_AW-1:0]      wr_second;

   assign wr_second = wr_ff + ntlv_pkg::FIFO_AW'(1);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign count     = cnt_ff;

   always_comb begin
      wr_in  = wr_ff + ntlv_pkg::FIFO_AW'(push.num);
      rd_in  = rd_ff + ntlv_pkg::FIFO_AW'(pop);
      cnt_in = cnt_ff + ntlv_pkg::FIFO_CW'(push.num) - ntlv_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_second] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `NTLV_ASSERT_NOW(a_fill_bound, clock, reset, int'(cnt_ff) <= ntlv_pkg::FIFO_DEPTH, "result queue fill beyond depth")
   `NTLV_ASSERT_NOW(a_no_overflow, clock, reset, (int'(cnt_ff) + int'(push.num)) <= ntlv_pkg::FIFO_DEPTH, "result queue would overflow")
   `NTLV_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, (cnt_ff == '0) && (wr_ff == rd_ff), "result queue not empty after reset")

endmodule

[sv/navdata_packet_tlv_parser_top.sv]
// Accepted bytes are registered, decoded, and their words queued for rsp_valid.
// Throughput: one byte per cycle while req_stall is low; a byte that closes a
// packet with a field pending gives two words, drained one per cycle while
// rsp_stall is low from an eight-word result queue.
// Reset is synchronous and active high: the parser returns to the header phase,
// the queue empties and the option tag registers take their default values.
module navdata_packet_tlv_parser_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ntlv_pkg::ntlv_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ntlv_pkg::ntlv_rsp_type rsp_payload,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   ntlv_pkg::ntlv_cfg_type        cfg;
   ntlv_pkg::ntlv_push_type       push;
   logic                          busy;
   logic                          in_accept;
   logic                          pop;
   logic [ntlv_pkg::FIFO_CW-1:0]  count;
   logic [ntlv_pkg::FIFO_CW:0]    committed;

   // Room is kept for two words from the byte in decode and two from the next one.
   assign committed = {1'b0, count} + (busy ? (ntlv_pkg::FIFO_CW+1)'(2) : '0);
   assign req_stall = (committed > (ntlv_pkg::FIFO_CW+1)'(ntlv_pkg::FIFO_DEPTH - 2));
   assign in_accept = req_valid & ~req_stall;
   assign pop       = rsp_valid & ~rsp_stall;

   ntlv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ntlv_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_data   (req_payload),
      .cfg       (cfg),
      .busy      (busy),
      .push      (push)
   );

   ntlv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .count     (count)
   );

endmodule
